// ===== hw/rtl/particle_pool_tick_spawn_compact_defines.svh =====
// Assertion macros shared by the particle pool RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PARTICLE_POOL_TICK_SPAWN_COMPACT_DEFINES_SVH
`define PARTICLE_POOL_TICK_SPAWN_COMPACT_DEFINES_SVH

// Implication check, disabled during reset.
`define PPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define PPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ppt_pkg.sv =====
// Package for the particle pool block: constants, slot record type, op codes.
// No dependencies.
package ppt_pkg;
    localparam int POOL_SIZE_DEF  = 256;
    localparam int HARD_LIMIT_DEF = 10000;
    localparam logic [15:0] DEFAULT_STEP = 16'd1092;

    localparam logic [1:0] OP_SPAWN = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [23:0] LIFE_MIN = 24'h800000;

    // One pool slot as it sits in memory.
    typedef struct packed {
        logic [15:0] position;
        logic [15:0] velocity;
        logic [23:0] life;
        logic [31:0] distance;
        logic [31:0] appearance;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);
endpackage

// ===== hw/rtl/ppt_slot_ram.sv =====
// Slot memory of the particle pool: one write port, one registered read port.
// Depends on ppt_pkg for the slot record width.
module ppt_slot_ram #(
    parameter int DEPTH = ppt_pkg::POOL_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [ppt_pkg::SLOT_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [ppt_pkg::SLOT_W-1:0] rdata
);
    logic [ppt_pkg::SLOT_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/ppt_update_unit.sv =====
// Shared slot update datapath for a tick: two registered stages.
// Depends on ppt_pkg for the slot record type.
module ppt_update_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ppt_pkg::slot_t    in_slot,
    input  logic [15:0]       dt,
    input  logic [15:0]       perimeter,
    input  logic [31:0]       max_dist,
    output logic              out_valid,
    output ppt_pkg::slot_t    out_slot
);
    logic           s1_valid_reg;
    ppt_pkg::slot_t s1_slot_reg;
    logic [30:0]    s1_mag_reg;
    logic           s1_neg_reg;
    logic [24:0]    s1_life_reg;
    logic           out_valid_reg;
    ppt_pkg::slot_t out_slot_reg;

    logic [15:0] vabs;
    logic [46:0] dprod;
    logic [32:0] dsum;
    logic [31:0] dnew;
    logic [15:0] mv;
    logic [15:0] pnew;
    logic [23:0] lnew;

    assign vabs = in_slot.velocity[15] ? (16'd0 - in_slot.velocity) : in_slot.velocity;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: velocity times time step, life subtraction.
    always_ff @(posedge clk)
    begin
        s1_slot_reg  <= in_slot;
        s1_mag_reg   <= 31'({16'd0, vabs} * {16'd0, dt});
        s1_neg_reg   <= in_slot.velocity[15];
        s1_life_reg  <= 25'({in_slot.life[23], in_slot.life}) - 25'({9'd0, dt});
    end

    // Stage two: distance, position, death check.
    always_comb
    begin
        dprod = 47'(s1_mag_reg) * 47'(perimeter);
        dsum  = {1'b0, s1_slot_reg.distance} + 33'(dprod >> 20);
        dnew  = dsum[32] ? 32'hFFFFFFFF : dsum[31:0];
        mv    = s1_mag_reg[27:12];
        pnew  = s1_neg_reg ? s1_slot_reg.position - mv : s1_slot_reg.position + mv;
        if (s1_life_reg[24] != s1_life_reg[23])
        begin
            lnew = ppt_pkg::LIFE_MIN;
        end
        else
        begin
            lnew = s1_life_reg[23:0];
        end
        if (dnew > max_dist)
        begin
            lnew = 24'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg           <= s1_slot_reg;
        out_slot_reg.distance  <= dnew;
        out_slot_reg.position  <= pnew;
        out_slot_reg.life      <= lnew;
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
endmodule

// ===== hw/rtl/particle_pool_tick_spawn_compact.sv =====
// Particle pool top level: sequencer, configuration registers, result register.
// Depends on ppt_pkg, ppt_slot_ram, ppt_update_unit and the defines header.
//
// A particle pool held in one slot memory. A spawn scans for the lowest
// dead slot, one slot a cycle; a tick streams every live slot through the
// two-stage update unit and writes the live ones back compacted, then
// clears the vacated tail; a read fetches one slot. The single memory
// read port lets each pass read one slot at a time. After reset a clearing
// pass zeroes the memory before the first item is taken. in_stall is high
// during the clearing pass, while an item is being worked on or while a
// result waits.
`include "particle_pool_tick_spawn_compact_defines.svh"
module particle_pool_tick_spawn_compact #(
    parameter int POOL_SIZE  = ppt_pkg::POOL_SIZE_DEF,
    parameter int HARD_LIMIT = ppt_pkg::HARD_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] time_step,
    input  logic [15:0] spawn_position,
    input  logic signed [15:0] spawn_velocity,
    input  logic [22:0] spawn_life,
    input  logic [7:0]  spawn_size,
    input  logic [7:0]  spawn_red,
    input  logic [7:0]  spawn_green,
    input  logic [7:0]  spawn_blue,
    input  logic [7:0]  slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [8:0]  active_count,
    output logic [15:0] read_position,
    output logic signed [23:0] read_life,
    output logic [7:0]  read_size,
    output logic [7:0]  read_red,
    output logic [7:0]  read_green,
    output logic [7:0]  read_blue
);
    localparam int AW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] FULL = CW'(POOL_SIZE);
    localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);
    localparam logic [IW-1:0] DRAIN = IW'(POOL_SIZE + 2);
    localparam logic REPLACE_OK = (POOL_SIZE < HARD_LIMIT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] live_reg, live_next;
    logic [15:0]   perim_reg;
    logic [31:0]   maxd_reg;
    logic [15:0]   dt_reg;
    logic [7:0]    ridx_reg;
    ppt_pkg::slot_t spawn_reg;
    logic          ovalid_reg, ovalid_next;
    logic          acc_reg, acc_next;
    ppt_pkg::slot_t rslot_reg, rslot_next;
    logic          rd_pend_reg, rd_pend_next;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    ppt_pkg::slot_t wdata, rdata;
    logic           uv_in, uv_out;
    ppt_pkg::slot_t uslot;
    logic           in_acc, out_acc;
    logic           rd_live;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || ovalid_reg;
    assign rd_live  = ($signed(rdata.life) > 0);

    ppt_slot_ram #(.DEPTH(POOL_SIZE), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    ppt_update_unit u_upd (
        .clk(clk), .rst_n(rst_n), .in_valid(uv_in), .in_slot(rdata), .dt(dt_reg),
        .perimeter(perim_reg), .max_dist(maxd_reg), .out_valid(uv_out), .out_slot(uslot)
    );

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perim_reg <= '0;
            maxd_reg  <= 32'hFFFFFFFF;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0)
            begin
                perim_reg <= pwdata[15:0];
            end
            else if (paddr == 3'd4)
            begin
                maxd_reg <= pwdata;
            end
        end
    end
    assign prdata = (paddr == 3'd0) ? {16'd0, perim_reg} :
                    (paddr == 3'd4) ? maxd_reg : 32'd0;

    // Captured input item.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dt_reg   <= (time_step == 16'd0) ? ppt_pkg::DEFAULT_STEP : time_step;
            ridx_reg <= slot_index;
            spawn_reg.position   <= spawn_position;
            spawn_reg.velocity   <= spawn_velocity;
            spawn_reg.life       <= {1'b0, spawn_life};
            spawn_reg.distance   <= '0;
            spawn_reg.appearance <= {spawn_size, spawn_red, spawn_green, spawn_blue};
        end
    end

    // Memory addressing: the read address follows the scan index.
    assign raddr = idx_reg[AW-1:0];
    assign uv_in = (state_reg == ST_TICK) && rd_pend_reg && rd_live;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        wptr_next    = wptr_reg;
        live_next    = live_reg;
        ovalid_next  = ovalid_reg && !out_acc;
        acc_next     = acc_reg;
        rslot_next   = rslot_reg;
        rd_pend_next = 1'b0;
        we           = 1'b0;
        waddr        = idx_reg[AW-1:0];
        wdata        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    state_next = ST_IDLE;
                    idx_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    wptr_next = '0;
                    rslot_next = '0;
                    acc_next = 1'b1;
                    unique case (opcode)
                        ppt_pkg::OP_SPAWN: state_next = ST_SCAN;
                        ppt_pkg::OP_TICK:  state_next = ST_TICK;
                        ppt_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                            idx_next = IW'(slot_index);
                        end
                        ppt_pkg::OP_NOP:   ovalid_next = 1'b1;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // rdata holds the data for the address before idx, from the registered read.
                rd_pend_next = 1'b1;
                if (rd_pend_reg && !rd_live)
                begin
                    we = 1'b1;
                    waddr = AW'(idx_reg - 1'b1);
                    wdata = spawn_reg;
                    if (live_reg < FULL)
                    begin
                        live_next = live_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (idx_reg == IW'(POOL_SIZE))
                begin
                    if (REPLACE_OK)
                    begin
                        we = 1'b1;
                        waddr = '0;
                        wdata = spawn_reg;
                    end
                    acc_next = REPLACE_OK;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TICK:
            begin
                if (idx_reg <= LAST)
                begin
                    rd_pend_next = 1'b1;
                end
                if (uv_out)
                begin
                    we = 1'b1;
                    waddr = wptr_reg[AW-1:0];
                    wdata = uslot;
                    if ($signed(uslot.life) > 0)
                    begin
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == DRAIN)
                begin
                    live_next = (uv_out && $signed(uslot.life) > 0) ?
                                wptr_reg + 1'b1 : wptr_reg;
                    idx_next = IW'(live_next);
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (idx_reg >= IW'(POOL_SIZE))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    we = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (!rd_pend_reg)
                begin
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    if (ridx_reg < 8'(POOL_SIZE > 255 ? 255 : POOL_SIZE) ||
                        POOL_SIZE > 255)
                    begin
                        rslot_next = rdata;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            wptr_reg    <= '0;
            live_reg    <= '0;
            ovalid_reg  <= 1'b0;
            acc_reg     <= 1'b1;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            wptr_reg    <= wptr_next;
            live_reg    <= live_next;
            ovalid_reg  <= ovalid_next;
            acc_reg     <= acc_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rslot_reg <= rslot_next;
    end

    // Result ports.
    assign out_valid     = ovalid_reg;
    assign accepted      = acc_reg;
    assign active_count  = 9'(live_reg);
    assign read_position = rslot_reg.position;
    assign read_life     = rslot_reg.life;
    assign read_size     = rslot_reg.appearance[31:24];
    assign read_red      = rslot_reg.appearance[23:16];
    assign read_green    = rslot_reg.appearance[15:8];
    assign read_blue     = rslot_reg.appearance[7:0];

    `PPT_ASSERT_IMP(a_live_bound, clk, rst_n, 1'b1, live_reg <= FULL)
    `PPT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_acc)
    `PPT_ASSERT_IMP(a_wptr_bound, clk, rst_n, state_reg == ST_TICK, wptr_reg <= FULL)
    `PPT_ASSERT_NXT(a_done_valid, clk, rst_n, state_reg == ST_DONE, ovalid_reg)
endmodule
